### hw/rtl/linear_probe_hash_map_top_defines.svh
// assertion macros for the linear probing hash table
// used by linear_probe_hash_map_top only
`ifndef LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_TOP_DEFINES_SVH

// same-cycle implication
`define LPHM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lphm assertion failed");

// next-cycle implication
`define LPHM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lphm assertion failed");

`endif

### hw/rtl/lphm_pkg.sv
// shared constants, codes and control structs for the hash table
// no dependencies
`timescale 1ns / 1ps

package lphm_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int KEY_W          = 32;
  localparam int DATA_W         = 32;
  localparam int CMD_W          = 2;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_GONE  = 2'd2
  } slot_st_t;

  // controller to datapath
  typedef struct packed {
    logic clear;   // one step of the status clearing sweep
    logic load;    // take the input beat, start home slot
    logic home;    // issue first read at home slot
    logic probe;   // examine current slot, read the next
    logic commit;  // write back and load the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic cmd_known;
    logic home_done;
    logic probe_stop;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/lphm_mod.sv
// home slot unit: key modulo table size
// mask for a power of two size, else reciprocal multiply, subtract and correct, all registered; uses lphm_pkg
`timescale 1ns / 1ps

module lphm_mod #(
  parameter int TABLE_SIZE = lphm_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lphm_pkg::KEY_W-1:0]    dividend,
  output logic [$clog2(TABLE_SIZE)-1:0] rem,
  output logic                          done
);
  import lphm_pkg::*;

  localparam int IW      = $clog2(TABLE_SIZE);
  localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (start) begin
          rem <= dividend[IW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else if (start) begin
          done <= 1'b1;
        end
      end
    end else begin : g_recip
      // scaled reciprocal, the quotient estimate is short by at most one
      localparam int SH = KEY_W - 1 + IW;
      localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / 64'(TABLE_SIZE);
      localparam logic [KEY_W-1:0] RECIP = RECIP_FULL[KEY_W-1:0];
      localparam logic [IW:0] DIV = (IW + 1)'(TABLE_SIZE);
      localparam logic [2*IW+1:0] DIV_W = (2 * IW + 2)'(TABLE_SIZE);

      logic [2*KEY_W-1:0] prod;
      logic [IW:0]        dvd_lo;
      logic [IW:0]        quo_lo;
      logic [2*IW+1:0]    quo_n;
      logic [IW:0]        part;
      logic [IW:0]        part_next;
      logic [IW:0]        diff;
      logic [1:0]         stage;

      // the remainder estimate is below twice the size, so low bits suffice
      assign quo_lo    = prod[SH +: (IW + 1)];
      assign quo_n     = (2 * IW + 2)'(quo_lo) * DIV_W;
      assign part_next = dvd_lo - quo_n[IW:0];
      assign diff      = part - DIV;

      always_ff @(posedge clk) begin
        if (start) begin
          prod   <= (2 * KEY_W)'(dividend) * (2 * KEY_W)'(RECIP);
          dvd_lo <= dividend[IW:0];
        end
        part <= part_next;
        rem  <= (part >= DIV) ? diff[IW-1:0] : part[IW-1:0];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          stage <= '0;
          done  <= 1'b0;
        end else begin
          stage <= {stage[0], start};
          if (start) begin
            done <= 1'b0;
          end else if (stage[1]) begin
            done <= 1'b1;
          end
        end
      end
    end
  endgenerate

endmodule

### hw/rtl/lphm_ctrl.sv
// sequencing state machine: clear sweep, home slot, probe walk, write back
// uses lphm_pkg structs
`timescale 1ns / 1ps

module lphm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lphm_pkg::dp_stat_t   stat,
  output lphm_pkg::ctrl_cmd_t  cmd
);
  import lphm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_PROBE,
    S_COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= stat.cmd_known ? S_HOME : S_COMMIT;
        end
        S_HOME: begin
          if (stat.home_done) state <= S_PROBE;
        end
        S_PROBE: begin
          if (stat.probe_stop) state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign cmd.clear  = (state == S_CLEAR);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.home   = (state == S_HOME) && stat.home_done;
  assign cmd.probe  = (state == S_PROBE);
  assign cmd.commit = (state == S_COMMIT) && stat.out_free;

endmodule

### hw/rtl/lphm_dp.sv
// datapath: slot memories, probe address walk, result and output register
// uses lphm_pkg, instantiates lphm_mod
`timescale 1ns / 1ps

module lphm_dp #(
  parameter int TABLE_SIZE = lphm_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lphm_pkg::ctrl_cmd_t           cmd,
  output lphm_pkg::dp_stat_t            stat,
  input  logic [lphm_pkg::CMD_W-1:0]    command,
  input  logic [lphm_pkg::KEY_W-1:0]    key,
  input  logic [lphm_pkg::DATA_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lphm_pkg::DATA_W-1:0]   read_data,
  output logic                          hit,
  output logic                          table_full,
  output logic [lphm_pkg::DATA_W-1:0]   stored_key_count
);
  import lphm_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  // slot memories
  slot_st_t          st_mem   [TABLE_SIZE];
  logic [KEY_W-1:0]  key_mem  [TABLE_SIZE];
  logic [DATA_W-1:0] data_mem [TABLE_SIZE];

  slot_st_t          rd_st;
  logic [KEY_W-1:0]  rd_key;
  logic [DATA_W-1:0] rd_data;

  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] value_r;

  logic [IW-1:0] home_idx;
  logic          home_done;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] eval_idx;
  logic [IW-1:0] next_addr;
  logic [CW-1:0] probe_cnt;
  logic [IW-1:0] clr_addr;

  logic              found_vld;
  logic [IW-1:0]     found_idx;
  logic [DATA_W-1:0] found_data;
  logic              free_vld;
  logic [IW-1:0]     free_idx;
  logic [DATA_W-1:0] key_total;

  logic is_lookup, is_insert, is_delete;
  logic slot_empty, slot_gone, slot_match, lap_end;
  logic do_fresh, do_update, do_delete;
  logic st_we, key_we, data_we;
  logic [IW-1:0] st_wa, data_wa;
  slot_st_t st_wd;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    return (a == LAST_IDX) ? '0 : a + IW'(1);
  endfunction

  lphm_mod #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (key),
    .rem      (home_idx),
    .done     (home_done)
  );

  assign is_lookup = (cmd_r == CMD_LOOKUP);
  assign is_insert = (cmd_r == CMD_INSERT);
  assign is_delete = (cmd_r == CMD_DELETE);

  // slot under examination
  assign slot_empty = (rd_st == ST_EMPTY);
  assign slot_gone  = (rd_st == ST_GONE);
  assign slot_match = (rd_st == ST_USED) && (rd_key == key_r);
  assign lap_end    = (probe_cnt == CW'(TABLE_SIZE - 1));

  assign stat.clr_last   = (clr_addr == LAST_IDX);
  assign stat.cmd_known  = (command == CMD_LOOKUP) || (command == CMD_INSERT) ||
                           (command == CMD_DELETE);
  assign stat.home_done  = home_done;
  assign stat.probe_stop = slot_empty || slot_match || lap_end;
  assign stat.out_free   = !out_valid || !out_stall;

  assign rd_addr = cmd.home ? home_idx : next_addr;

  always_ff @(posedge clk) begin
    rd_st   <= st_mem[rd_addr];
    rd_key  <= key_mem[rd_addr];
    rd_data <= data_mem[rd_addr];
  end

  // write back decisions
  assign do_fresh  = cmd.commit && is_insert && !found_vld && free_vld;
  assign do_update = cmd.commit && is_insert && found_vld;
  assign do_delete = cmd.commit && is_delete && found_vld;

  always_comb begin
    st_we = 1'b0;
    st_wa = clr_addr;
    st_wd = ST_EMPTY;
    if (cmd.clear) begin
      st_we = 1'b1;
    end else if (do_fresh) begin
      st_we = 1'b1;
      st_wa = free_idx;
      st_wd = ST_USED;
    end else if (do_delete) begin
      st_we = 1'b1;
      st_wa = found_idx;
      st_wd = ST_GONE;
    end
  end

  assign key_we  = do_fresh;
  assign data_we = do_fresh || do_update;
  assign data_wa = found_vld ? found_idx : free_idx;

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[free_idx] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_wa] <= value_r;
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= command;
      key_r   <= key;
      value_r <= value;
    end
  end

  // probe walk
  always_ff @(posedge clk) begin
    if (cmd.home) begin
      eval_idx  <= home_idx;
      next_addr <= wrap_inc(home_idx);
      probe_cnt <= '0;
    end else if (cmd.probe) begin
      eval_idx  <= next_addr;
      next_addr <= wrap_inc(next_addr);
      probe_cnt <= probe_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_vld <= 1'b0;
      free_vld  <= 1'b0;
    end else if (cmd.probe) begin
      if (slot_match) begin
        found_vld  <= 1'b1;
        found_idx  <= eval_idx;
        found_data <= rd_data;
      end
      // first deleted slot wins, else the empty one that ends the walk
      if (!free_vld && (slot_empty || slot_gone)) begin
        free_vld <= 1'b1;
        free_idx <= eval_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_total <= '0;
    end else if (do_fresh && (key_total != '1)) begin
      key_total <= key_total + DATA_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      stored_key_count <= '0;
    end else if (cmd.commit) begin
      out_valid        <= 1'b1;
      stored_key_count <= (do_fresh && (key_total != '1)) ? key_total + DATA_W'(1)
                                                          : key_total;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      read_data  <= (is_lookup && found_vld) ? found_data : '0;
      hit        <= found_vld;
      table_full <= is_insert && !found_vld && !free_vld;
    end
  end

endmodule

### hw/rtl/linear_probe_hash_map_top.sv
// channel  fields                                      handshake
// input    command, key, value                         in_valid / in_stall
// output   read_data, hit, table_full, stored_key_count out_valid / out_stall
//
// a beat is loaded, its home slot found (masked for a power of two size, else by
// the reciprocal remainder), its slots probed and its result written back. probes
// are one per slot read, set by the single read port of the slot memories, at most
// TABLE_SIZE. an unused command skips the home slot and the probes.
// after reset the slot status memory is swept over all TABLE_SIZE slots, input stalled.
// a result waits in the output register; the next beat is taken meanwhile,
// and its write back waits until the register is free.
`timescale 1ns / 1ps
`include "linear_probe_hash_map_top_defines.svh"

module linear_probe_hash_map_top #(
  parameter int TABLE_SIZE = lphm_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lphm_pkg::CMD_W-1:0]    command,
  input  logic [lphm_pkg::KEY_W-1:0]    key,
  input  logic [lphm_pkg::DATA_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lphm_pkg::DATA_W-1:0]   read_data,
  output logic                          hit,
  output logic                          table_full,
  output logic [lphm_pkg::DATA_W-1:0]   stored_key_count
);
  import lphm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lphm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lphm_dp #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .command          (command),
    .key              (key),
    .value            (value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_data        (read_data),
    .hit              (hit),
    .table_full       (table_full),
    .stored_key_count (stored_key_count)
  );

  // a taken beat keeps the input stalled while it is worked on
  `LPHM_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // a write back never lands on a result that is still held
  `LPHM_ASSERT_IMP(a_commit_slot_free, clk, rst, cmd.commit, !(out_valid && out_stall))
  // a full table and a hit exclude each other
  `LPHM_ASSERT_IMP(a_full_no_hit, clk, rst, out_valid && table_full, !hit && read_data == '0)
  // the key count never goes down
  `LPHM_ASSERT_IMP(a_count_mono, clk, rst, !$past(rst),
                   stored_key_count >= $past(stored_key_count))

endmodule

### test/linear_probe_hash_map_top_tb.sv
// self-checking testbench for the linear probing key/data table
// depends on lphm_pkg and linear_probe_hash_map_top; keeps its own copy of the table
`timescale 1ns / 1ps

module linear_probe_hash_map_top_tb;
  import lphm_pkg::*;

  localparam int MAP_SLOTS = TABLE_SIZE_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              table_full;
    logic [DATA_W-1:0] stored_key_count;
  } map_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  command = CMD_LOOKUP;
  logic [KEY_W-1:0]  key = '0;
  logic [DATA_W-1:0] value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] read_data;
  logic              hit;
  logic              table_full;
  logic [DATA_W-1:0] stored_key_count;

  // shadow copy of the table
  slot_st_t          tbl_status [MAP_SLOTS];
  logic [KEY_W-1:0]  tbl_key    [MAP_SLOTS];
  logic [DATA_W-1:0] tbl_data   [MAP_SLOTS];
  logic [DATA_W-1:0] keys_added;

  map_reply_t        expected_replies[$];
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                beats_sent = 0;
  int                replies_checked = 0;
  int                error_count = 0;
  int                full_flags_seen = 0;
  logic [23:0]       upper_pool [4] = '{24'h000000, 24'hFFFFFF, 24'h5A5A5A, 24'hA5A5A5};

  linear_probe_hash_map_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .key(key),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .hit(hit),
    .table_full(table_full),
    .stored_key_count(stored_key_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", expected_replies.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // probe one lap from the home slot and update the shadow table
  function automatic map_reply_t apply_map_op(input logic [CMD_W-1:0] cmd,
                                              input logic [KEY_W-1:0] k,
                                              input logic [DATA_W-1:0] v);
    map_reply_t r;
    int idx;
    int found;
    int free_idx;
    r = '0;
    found = -1;
    free_idx = -1;
    if (cmd != CMD_UNUSED) begin
      idx = int'(k % KEY_W'(MAP_SLOTS));
      for (int n = 0; n < MAP_SLOTS; n++) begin
        if (tbl_status[idx] == ST_EMPTY) begin
          if (free_idx < 0) free_idx = idx;
          break;
        end
        if (tbl_status[idx] == ST_USED && tbl_key[idx] == k) begin
          found = idx;
          break;
        end
        if (tbl_status[idx] == ST_GONE && free_idx < 0) free_idx = idx;
        idx = (idx + 1) % MAP_SLOTS;
      end
      case (cmd)
        CMD_LOOKUP: begin
          if (found >= 0) begin
            r.read_data = tbl_data[found];
            r.hit = 1'b1;
          end
        end
        CMD_INSERT: begin
          if (found >= 0) begin
            tbl_data[found] = v;
            r.hit = 1'b1;
          end else if (free_idx >= 0) begin
            tbl_status[free_idx] = ST_USED;
            tbl_key[free_idx] = k;
            tbl_data[free_idx] = v;
            if (keys_added != '1) keys_added = keys_added + 1'b1;
          end else begin
            r.table_full = 1'b1;
          end
        end
        CMD_DELETE: begin
          if (found >= 0) begin
            tbl_status[found] = ST_GONE;
            r.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.stored_key_count = keys_added;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // sender: random idle gaps, then hold the beat until it is taken
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                           input logic [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
    expected_replies.push_back(apply_map_op(cmd, k, v));
    beats_sent++;
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    map_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        flag_error($sformatf("result with none expected: rd=%h hit=%b full=%b count=%0d",
                             read_data, hit, table_full, stored_key_count));
      end else begin
        want = expected_replies.pop_front();
        if (read_data !== want.read_data || hit !== want.hit ||
            table_full !== want.table_full || stored_key_count !== want.stored_key_count)
          flag_error($sformatf({"result %0d: expected rd=%h hit=%b full=%b count=%0d,",
                                " got rd=%h hit=%b full=%b count=%0d"},
                               replies_checked, want.read_data, want.hit, want.table_full,
                               want.stored_key_count, read_data, hit, table_full,
                               stored_key_count));
        if (want.table_full) full_flags_seen++;
        replies_checked++;
      end
    end
  end

  // collisions, wrap past the last slot, deleted slots, unused command
  task automatic test_basic_ops();
    idle_pct = 0;
    stall_pct = 0;
    send_beat(CMD_LOOKUP, 32'h0, 32'h1111_1111);
    send_beat(CMD_DELETE, 32'h5, 32'h0);
    send_beat(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_beat(CMD_INSERT, 32'h100, 32'h0);
    send_beat(CMD_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_beat(CMD_INSERT, 32'hFFFF_FEFF, 32'h5A5A_5A5A);
    send_beat(CMD_LOOKUP, 32'hFFFF_FEFF, 32'h0);
    send_beat(CMD_INSERT, 32'h0, 32'h1234_5678);
    send_beat(CMD_LOOKUP, 32'h0, 32'h0);
    send_beat(CMD_LOOKUP, 32'h100, 32'h0);
    send_beat(CMD_DELETE, 32'h0, 32'hFFFF_FFFF);
    send_beat(CMD_LOOKUP, 32'h100, 32'h0);
    send_beat(CMD_LOOKUP, 32'h0, 32'h0);
    send_beat(CMD_DELETE, 32'h0, 32'h0);
    send_beat(CMD_INSERT, 32'h200, 32'h8000_0001);
    send_beat(CMD_UNUSED, 32'h100, 32'hDEAD_BEEF);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_beat(CMD_INSERT, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0);
    send_beat(CMD_DELETE, 32'hFFFF_FFFF, 32'h0);
    send_beat(CMD_DELETE, 32'hFFFF_FEFF, 32'h0);
    send_beat(CMD_DELETE, 32'h100, 32'h0);
    send_beat(CMD_DELETE, 32'h200, 32'h0);
    send_beat(CMD_LOOKUP, 32'hFFFF_FEFF, 32'h0);
    // hold off until the table has answered everything
    wait_for_replies();
  endtask

  // keys mostly from a small pool so that slots collide and get reused
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom();
    if (r < 10) return 32'hFFFF_FFFF;
    return {upper_pool[$urandom_range(0, 3)], 8'($urandom_range(0, 23))};
  endfunction

  task automatic test_random_traffic(input int count, input int idle, input int stall);
    int r;
    logic [CMD_W-1:0] cmd;
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) cmd = CMD_INSERT;
      else if (r < 80) cmd = CMD_LOOKUP;
      else if (r < 95) cmd = CMD_DELETE;
      else cmd = CMD_UNUSED;
      send_beat(cmd, pick_key(), $urandom());
    end
    wait_for_replies();
  endtask

  // fill every free slot, then exercise a full table
  task automatic test_full_table();
    idle_pct = 36;
    stall_pct = 36;
    for (int i = 0; i < MAP_SLOTS + 4; i++)
      send_beat(CMD_INSERT, 32'h0100_0000 + i, $urandom());
    send_beat(CMD_INSERT, 32'h0100_0000, 32'hC0DE_0001);
    send_beat(CMD_LOOKUP, 32'h0200_0000, 32'h0);
    send_beat(CMD_DELETE, 32'h0100_0005, 32'h0);
    send_beat(CMD_INSERT, 32'h0200_0000, 32'hC0DE_0002);
    send_beat(CMD_INSERT, 32'h0200_0001, 32'hC0DE_0003);
    send_beat(CMD_LOOKUP, 32'h0200_0000, 32'h0);
    send_beat(CMD_LOOKUP, 32'h0100_0000, 32'h0);
    wait_for_replies();
  endtask

  initial begin
    foreach (tbl_status[i]) begin
      tbl_status[i] = ST_EMPTY;
      tbl_key[i] = '0;
      tbl_data[i] = '0;
    end
    keys_added = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 45, 0);
    test_random_traffic(250, 0, 45);
    test_random_traffic(250, 36, 36);
    test_full_table();
    wait_for_replies();
    repeat (400) @(posedge clk);
    $display("%0d beats sent, %0d results checked, %0d table-full answers, %0d mismatches",
             beats_sent, replies_checked, full_flags_seen, error_count);
    $display("covered collisions, wrap-around, deleted slot reuse and a completely full table");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lphm_pkg.sv
hw/rtl/lphm_mod.sv
hw/rtl/lphm_ctrl.sv
hw/rtl/lphm_dp.sv
hw/rtl/linear_probe_hash_map_top.sv
test/linear_probe_hash_map_top_tb.sv
